FILE: rtl/hmm_scaled_forward_unit_assert.svh
// Assertion macros shared by the scaled forward unit RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef HMM_SCALED_FORWARD_UNIT_ASSERT_SVH
`define HMM_SCALED_FORWARD_UNIT_ASSERT_SVH

// Same-cycle implication check.
`define HSF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hsf assertion failed");

// Next-cycle implication check.
`define HSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hsf assertion failed");

`endif

FILE: rtl/hsf_pkg.sv
// Package for the scaled forward unit: request types, state encoding, widths.
// Used by hsf_divider and hmm_scaled_forward_unit; depends on nothing.
package hsf_pkg;

    localparam int MAX_STATES     = 16;
    localparam int PROB_FRAC_BITS = 32;
    localparam int STATE_W        = $clog2(MAX_STATES);
    localparam int COUNT_W        = STATE_W + 1;
    localparam int FWD_W          = PROB_FRAC_BITS + 1;
    localparam int ACC_W          = FWD_W + PROB_FRAC_BITS + STATE_W;
    localparam int ACC_HI_W       = ACC_W - 64;
    localparam int U_W            = 38;
    localparam int SCALE_W        = PROB_FRAC_BITS + 8;
    localparam int REM_W          = SCALE_W + 1;
    localparam int DIV_CNT_W      = $clog2(PROB_FRAC_BITS);

    localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

    localparam logic [1:0] OP_LOAD_TRANS = 2'd0;
    localparam logic [1:0] OP_LOAD_INIT  = 2'd1;
    localparam logic [1:0] OP_LIKELIHOOD = 2'd2;
    localparam logic [1:0] OP_BEGIN      = 2'd3;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_ZERO_SCALE = 1'b1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [STATE_W-1:0] row_index;
        logic [STATE_W-1:0] col_index;
        logic [31:0]        value;
    } t_in_req;

    typedef struct packed {
        logic [FWD_W-1:0]   forward_value;
        logic [STATE_W-1:0] state_index;
        logic [SCALE_W-1:0] scale_sum;
        logic               last;
        logic               status;
    } t_out_req;

    typedef struct packed {
        logic               start;
        logic [U_W-1:0]     num;
        logic [SCALE_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [FWD_W-1:0] quot;
    } t_div_resp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRD,
        ST_FMUL,
        ST_FU,
        ST_MRD,
        ST_MMUL,
        ST_MACC,
        ST_L0,
        ST_L1,
        ST_L2,
        ST_L3,
        ST_CHECK,
        ST_ERR,
        ST_DSTART,
        ST_DWAIT,
        ST_EMIT
    } t_state;

endpackage

FILE: rtl/hsf_divider.sv
// Fractional restoring divider: floor(num * 2^F / den) for num not above den.
// Depends on hsf_pkg for widths and the request and response types.
module hsf_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hsf_pkg::t_div_req i_req,
    output hsf_pkg::t_div_resp o_resp
);

    logic [hsf_pkg::REM_W-1:0]     r_rem, n_rem;
    logic [hsf_pkg::FWD_W-1:0]     r_quot, n_quot;
    logic [hsf_pkg::SCALE_W-1:0]   r_den;
    logic [hsf_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy, r_done;
    logic [hsf_pkg::REM_W-1:0]     w_shift;
    logic                          w_ge;

    // One quotient bit per cycle after the integer bit.
    always_comb begin
        w_shift = {r_rem[hsf_pkg::REM_W-2:0], 1'b0};
        w_ge    = (w_shift >= {1'b0, r_den});
        n_rem   = w_ge ? (w_shift - {1'b0, r_den}) : w_shift;
        n_quot  = {r_quot[hsf_pkg::FWD_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == hsf_pkg::DIV_CNT_W'(hsf_pkg::PROB_FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= i_req.den;
            if ({2'b0, i_req.num} >= i_req.den) begin
                r_rem  <= {1'b0, {2'b0, i_req.num} - i_req.den};
                r_quot <= {{(hsf_pkg::FWD_W-1){1'b0}}, 1'b1};
            end else begin
                r_rem  <= {3'b0, i_req.num};
                r_quot <= '0;
            end
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_resp.busy = r_busy;
    assign o_resp.done = r_done;
    assign o_resp.quot = r_quot;

endmodule

FILE: rtl/hmm_scaled_forward_unit.sv
// Top level of the scaled forward unit: sequencer, tables, shared multiplier.
// Depends on hsf_pkg, hsf_divider and hmm_scaled_forward_unit_assert.svh.
`include "hmm_scaled_forward_unit_assert.svh"

// Scaled hidden Markov forward recursion in unsigned Q.32 fixed point. Load
// requests (transition entry, initial entry) and begin requests are taken
// while the unit is idle. Likelihood requests are buffered in state order;
// the request that completes a vector of N = num_states elements starts the
// recursion, and the input side stalls until the last result of that vector
// has been handed to the output register. One 32x32 multiplier is shared by
// all products. The first vector of a sequence steps through FRD, FMUL and
// FU per state; later vectors step through MRD, MMUL and MACC per
// multiply-accumulate, N*N of them, then L0 to L3 per state to apply the
// likelihood. Each result is then divided by the scale in the divider, which
// retires one quotient bit per cycle, and waits while the output side stalls.
// A zero scale produces a single error result with status set, after which
// likelihood requests are dropped until the next begin request.
// Configuration must only be written while the unit is idle.
module hmm_scaled_forward_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [hsf_pkg::COUNT_W-1:0]      i_cfg_wr_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  hsf_pkg::t_in_req                 i_in_req,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output hsf_pkg::t_out_req                o_out_req
);

    // Tables. The transition table is a real memory with a registered read.
    logic [31:0] r_trans_mem [hsf_pkg::MAX_STATES*hsf_pkg::MAX_STATES];
    logic [31:0] r_init_mem  [hsf_pkg::MAX_STATES];
    logic [31:0] r_lik_mem   [hsf_pkg::MAX_STATES];
    logic [31:0] r_trans_q, r_init_q, r_lik_q;

    // Previous forward vector resets to zero; unscaled values per state.
    logic [hsf_pkg::FWD_W-1:0] r_prev_fwd [hsf_pkg::MAX_STATES];
    logic [hsf_pkg::U_W-1:0]   r_u_buf    [hsf_pkg::MAX_STATES];

    hsf_pkg::t_state r_state, n_state;

    logic [hsf_pkg::COUNT_W-1:0] r_num_states;
    logic [hsf_pkg::COUNT_W-1:0] w_n;
    logic [hsf_pkg::COUNT_W-1:0] r_elem_cnt;
    logic                        r_first, r_aborted;
    logic [hsf_pkg::STATE_W-1:0] r_i, r_j;
    logic [hsf_pkg::ACC_W-1:0]   r_acc;
    logic [63:0]                 r_prod;
    logic [31:0]                 r_hi;
    logic [32:0]                 r_part;
    logic [hsf_pkg::SCALE_W-1:0] r_scale;
    logic                        r_out_valid;
    hsf_pkg::t_out_req           r_out;

    logic        w_in_acc, w_lik_acc, w_complete;
    logic        w_last_i, w_last_j, w_slot_free;
    logic        w_lik_drop, w_quot_ok;
    logic [31:0] w_mul_a, w_mul_b;
    logic [64:0] w_part_sum;
    logic [hsf_pkg::U_W-1:0]     w_u;
    logic [hsf_pkg::SCALE_W:0]   w_scale_sum;
    logic [hsf_pkg::SCALE_W-1:0] w_scale_next;
    logic [hsf_pkg::FWD_W-1:0]   w_fwd_i;

    hsf_pkg::t_div_req  w_div_req;
    hsf_pkg::t_div_resp w_div_resp;

    // A vector length of zero acts as one; anything above the table size is clamped.
    always_comb begin
        if (r_num_states == '0) begin
            w_n = {{(hsf_pkg::COUNT_W-1){1'b0}}, 1'b1};
        end else if (r_num_states > hsf_pkg::COUNT_W'(hsf_pkg::MAX_STATES)) begin
            w_n = hsf_pkg::COUNT_W'(hsf_pkg::MAX_STATES);
        end else begin
            w_n = r_num_states;
        end
    end

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_lik_acc  = w_in_acc && (i_in_req.opcode == hsf_pkg::OP_LIKELIHOOD) && !r_aborted;
    assign w_lik_drop = w_in_acc && (i_in_req.opcode == hsf_pkg::OP_LIKELIHOOD) && r_aborted;
    assign w_complete = (r_elem_cnt + 1'b1) >= w_n;
    assign w_last_i   = ({1'b0, r_i} + 1'b1) == w_n;
    assign w_last_j   = ({1'b0, r_j} + 1'b1) == w_n;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_fwd_i    = r_prev_fwd[r_i];

    // A quotient never exceeds one, which is 2^F in Q1.F.
    assign w_quot_ok  = !w_div_resp.quot[hsf_pkg::FWD_W-1]
                        || (w_div_resp.quot[hsf_pkg::FWD_W-2:0] == '0);

    // The first partial of the likelihood product keeps only its carry part.
    assign w_part_sum = {32'b0, r_part} + {1'b0, r_prod};

    // Unscaled value: first vector uses the top half of l*init, later vectors
    // the sum of the carried partials and the top partial.
    always_comb begin
        if (r_state == hsf_pkg::ST_FU) begin
            w_u = {6'b0, r_prod[63:32]};
        end else begin
            w_u = r_prod[hsf_pkg::U_W-1:0] + {5'b0, r_part};
        end
    end

    assign w_scale_sum  = {1'b0, r_scale} + {3'b0, w_u};
    assign w_scale_next = w_scale_sum[hsf_pkg::SCALE_W] ? hsf_pkg::SCALE_MAX
                                                         : w_scale_sum[hsf_pkg::SCALE_W-1:0];

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hsf_pkg::ST_IDLE: begin
                if (w_lik_acc && w_complete) begin
                    n_state = r_first ? hsf_pkg::ST_FRD : hsf_pkg::ST_MRD;
                end
            end
            hsf_pkg::ST_FRD:  n_state = hsf_pkg::ST_FMUL;
            hsf_pkg::ST_FMUL: n_state = hsf_pkg::ST_FU;
            hsf_pkg::ST_FU:   n_state = w_last_j ? hsf_pkg::ST_CHECK : hsf_pkg::ST_FRD;
            hsf_pkg::ST_MRD:  n_state = hsf_pkg::ST_MMUL;
            hsf_pkg::ST_MMUL: n_state = hsf_pkg::ST_MACC;
            hsf_pkg::ST_MACC: n_state = w_last_i ? hsf_pkg::ST_L0 : hsf_pkg::ST_MRD;
            hsf_pkg::ST_L0:   n_state = hsf_pkg::ST_L1;
            hsf_pkg::ST_L1:   n_state = hsf_pkg::ST_L2;
            hsf_pkg::ST_L2:   n_state = hsf_pkg::ST_L3;
            hsf_pkg::ST_L3:   n_state = w_last_j ? hsf_pkg::ST_CHECK : hsf_pkg::ST_MRD;
            hsf_pkg::ST_CHECK: begin
                n_state = (r_scale == '0) ? hsf_pkg::ST_ERR : hsf_pkg::ST_DSTART;
            end
            hsf_pkg::ST_ERR: begin
                if (w_slot_free) begin
                    n_state = hsf_pkg::ST_IDLE;
                end
            end
            hsf_pkg::ST_DSTART: n_state = hsf_pkg::ST_DWAIT;
            hsf_pkg::ST_DWAIT: begin
                if (w_div_resp.done) begin
                    n_state = hsf_pkg::ST_EMIT;
                end
            end
            hsf_pkg::ST_EMIT: begin
                if (w_slot_free) begin
                    n_state = w_last_j ? hsf_pkg::ST_IDLE : hsf_pkg::ST_DSTART;
                end
            end
            default: n_state = hsf_pkg::ST_IDLE;
        endcase
    end

    // Output logic: input stall, shared multiplier operands, divider start.
    always_comb begin
        o_in_stall      = 1'b1;
        w_mul_a         = '0;
        w_mul_b         = '0;
        w_div_req.start = 1'b0;
        w_div_req.num   = r_u_buf[r_j];
        w_div_req.den   = r_scale;
        unique case (r_state)
            hsf_pkg::ST_IDLE:   o_in_stall = 1'b0;
            hsf_pkg::ST_FMUL: begin
                w_mul_a = r_lik_q;
                w_mul_b = r_init_q;
            end
            hsf_pkg::ST_MMUL: begin
                w_mul_a = w_fwd_i[31:0];
                w_mul_b = r_trans_q;
            end
            hsf_pkg::ST_L0: begin
                w_mul_a = r_acc[31:0];
                w_mul_b = r_lik_q;
            end
            hsf_pkg::ST_L1: begin
                w_mul_a = r_acc[63:32];
                w_mul_b = r_lik_q;
            end
            hsf_pkg::ST_L2: begin
                w_mul_a = {{(32-hsf_pkg::ACC_HI_W){1'b0}}, r_acc[hsf_pkg::ACC_W-1:64]};
                w_mul_b = r_lik_q;
            end
            hsf_pkg::ST_DSTART: w_div_req.start = 1'b1;
            default: begin
            end
        endcase
    end

    hsf_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_resp  (w_div_resp)
    );

    // Table writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in_req.opcode == hsf_pkg::OP_LOAD_TRANS)) begin
            r_trans_mem[{i_in_req.row_index, i_in_req.col_index}] <= i_in_req.value;
        end
        if (w_in_acc && (i_in_req.opcode == hsf_pkg::OP_LOAD_INIT)) begin
            r_init_mem[i_in_req.row_index] <= i_in_req.value;
        end
        if (w_lik_acc) begin
            r_lik_mem[r_elem_cnt[hsf_pkg::STATE_W-1:0]] <= i_in_req.value;
        end
        r_trans_q <= r_trans_mem[{r_i, r_j}];
        r_init_q  <= r_init_mem[r_j];
        r_lik_q   <= r_lik_mem[r_j];
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        unique case (r_state) inside
            hsf_pkg::ST_IDLE: begin
                r_acc   <= '0;
                r_scale <= '0;
            end
            hsf_pkg::ST_MMUL: r_hi <= w_fwd_i[hsf_pkg::FWD_W-1] ? r_trans_q : 32'b0;
            hsf_pkg::ST_MACC: begin
                r_acc <= r_acc + {{hsf_pkg::ACC_HI_W{1'b0}}, r_prod}
                               + {{hsf_pkg::ACC_HI_W{1'b0}}, r_hi, 32'b0};
            end
            hsf_pkg::ST_L1: r_part <= {1'b0, r_prod[63:32]};
            hsf_pkg::ST_L2: r_part <= w_part_sum[64:32];
            hsf_pkg::ST_FU, hsf_pkg::ST_L3: begin
                r_u_buf[r_j] <= w_u;
                r_scale      <= w_scale_next;
                r_acc        <= '0;
            end
            default: begin
            end
        endcase
    end

    // Control registers, previous forward vector and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hsf_pkg::ST_IDLE;
            r_num_states <= hsf_pkg::COUNT_W'(2);
            r_elem_cnt   <= '0;
            r_first      <= 1'b1;
            r_aborted    <= 1'b0;
            r_i          <= '0;
            r_j          <= '0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < hsf_pkg::MAX_STATES; k++) begin
                r_prev_fwd[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_num_states <= i_cfg_wr_data;
            end
            // A new result may enter the output register in the same cycle
            // that the waiting one is taken.
            if (((r_state == hsf_pkg::ST_ERR) || (r_state == hsf_pkg::ST_EMIT))
                && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc && (i_in_req.opcode == hsf_pkg::OP_BEGIN)) begin
                r_elem_cnt <= '0;
                r_first    <= 1'b1;
                r_aborted  <= 1'b0;
            end
            if (w_lik_acc) begin
                r_elem_cnt <= w_complete ? '0 : r_elem_cnt + 1'b1;
                r_i        <= '0;
                r_j        <= '0;
            end
            unique case (r_state)
                hsf_pkg::ST_FU: r_j <= r_j + 1'b1;
                hsf_pkg::ST_MACC: r_i <= r_i + 1'b1;
                hsf_pkg::ST_L3: begin
                    r_i <= '0;
                    r_j <= r_j + 1'b1;
                end
                hsf_pkg::ST_CHECK: r_j <= '0;
                hsf_pkg::ST_ERR: begin
                    if (w_slot_free) begin
                        r_aborted <= 1'b1;
                    end
                end
                hsf_pkg::ST_EMIT: begin
                    if (w_slot_free) begin
                        r_prev_fwd[r_j] <= w_div_resp.quot;
                        r_j             <= r_j + 1'b1;
                        if (w_last_j) begin
                            r_first <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result payload; the error result carries zeros with last and status set.
    always_ff @(posedge i_clk) begin
        if ((r_state == hsf_pkg::ST_ERR) && w_slot_free) begin
            r_out.forward_value <= '0;
            r_out.state_index   <= '0;
            r_out.scale_sum     <= '0;
            r_out.last          <= 1'b1;
            r_out.status        <= hsf_pkg::STATUS_ZERO_SCALE;
        end else if ((r_state == hsf_pkg::ST_EMIT) && w_slot_free) begin
            r_out.forward_value <= w_div_resp.quot;
            r_out.state_index   <= r_j;
            r_out.scale_sum     <= r_scale;
            r_out.last          <= w_last_j;
            r_out.status        <= hsf_pkg::STATUS_OK;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    `HSF_ASSERT_NOW(a_err_is_last, r_out_valid && r_out.status, r_out.last && (r_out.forward_value == '0))
    `HSF_ASSERT_NOW(a_quot_range, w_div_resp.done, w_quot_ok)
    `HSF_ASSERT_NEXT(a_aborted_drop, w_lik_drop, $stable(r_elem_cnt))
    `HSF_ASSERT_NOW(a_idle_div_free, r_state == hsf_pkg::ST_IDLE, !w_div_resp.busy)

endmodule
